// ----- sv/svc_pkg.sv -----
// shared types and constants for the snapshot visibility check
package svc_pkg;

   localparam int ID_W         = 63;
   localparam int LIST_COUNT_W = 7;
   localparam int STATUS_W     = 3;
   localparam int CSR_IDX_W    = 1;

   // operation codes of an input item
   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // status codes of a result item
   localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_BOUNDS = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_ORDER      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL       = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_BOUND  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_BOUND = 1'b1;

   // query token walking along the cell chain
   typedef struct packed {
      logic            valid;
      logic [ID_W-1:0] id;
      logic            hit;
   } token_type;

endpackage

// ----- sv/svc_cell.sv -----
// one cell of the id chain: holds one in-progress id and checks the passing query token
module svc_cell import svc_pkg::*; #(
   parameter int CNT_W = 7,
   parameter int INDEX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [ID_W-1:0]  wr_id,
   input  logic [CNT_W-1:0] count,
   input  token_type        tok_prev,
   output token_type        tok_next
);

   logic [ID_W-1:0] entry_ff;
   logic [ID_W-1:0] entry_in;
   token_type       tok_ff;
   token_type       tok_in;
   logic            live;

   // entry holds a real id only below the fill count
   assign live = (CNT_W'(INDEX) < count);

   // id store
   assign entry_in = wr_en ? wr_id : entry_ff;

   // token picks up a hit when it meets its id here
   always_comb begin
      tok_in     = tok_prev;
      tok_in.hit = tok_prev.hit | (tok_prev.valid & live & (entry_ff == tok_prev.id));
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_next = tok_ff;

endmodule

// ----- sv/snapshot_visibility_check.sv -----
// top level of the snapshot visibility check: bounds, list control and the cell chain
//
//  channel  direction  handshake              payload
//  req_     in         req_valid / req_stall  req_operation, req_txn_id
//  rsp_     out        rsp_valid / rsp_stall  rsp_visible, rsp_status, rsp_list_count
//  csr_     in         csr_valid / csr_ready  csr_index, csr_data
//
// clear, add, unused codes and queries outside [low, high) give their item in the next cycle.
// a query inside [low, high) sends a token down the MAX_IDS cells, one cell a cycle, so its
// item is registered once the token leaves the last cell; one item is in work at a time.
// reset empties the list, sets both bounds to 1 and drops any pending item.
// req_stall is high while a query token is in the chain or the held item is stalled.
// csr_ready is always high.
module snapshot_visibility_check import svc_pkg::*; #(
   parameter int MAX_IDS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_operation,
   input  logic [ID_W-1:0]         req_txn_id,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_visible,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [LIST_COUNT_W-1:0] rsp_list_count,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [ID_W-1:0]         csr_data
);

   localparam int CNT_W = $clog2(MAX_IDS + 1);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_QUERY = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [ID_W-1:0]      low_bound_ff, low_bound_in;
   logic [ID_W-1:0]      high_bound_ff, high_bound_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [ID_W-1:0]      last_added_ff, last_added_in;
   logic                 pend_bad_ff, pend_bad_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_visible_ff, rsp_visible_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]     rsp_count_ff, rsp_count_in;

   op_type               op;
   logic                 accept;
   logic                 bad;
   logic                 below_low;
   logic                 at_high;
   logic                 add_ok;
   logic [STATUS_W-1:0]  add_status;
   logic [STATUS_W-1:0]  base_status;
   token_type            link [MAX_IDS+1];
   token_type            chain_out;

   assign op     = op_type'(req_operation);
   assign accept = req_valid & ~req_stall;

   // take a new item only when idle and the output register frees up
   assign req_stall = (state_ff != ST_IDLE) | (rsp_valid_ff & rsp_stall);
   assign csr_ready = 1'b1;

   // bound checks
   assign bad         = (low_bound_ff == '0) | (high_bound_ff == '0) |
                        (low_bound_ff > high_bound_ff);
   assign below_low   = (req_txn_id < low_bound_ff);
   assign at_high     = (req_txn_id >= high_bound_ff);
   assign base_status = bad ? STATUS_BAD_BOUNDS : STATUS_OK;

   // add checks in priority order
   always_comb begin
      add_ok = 1'b0;
      if (bad) begin
         add_status = STATUS_BAD_BOUNDS;
      end else if (req_txn_id <= last_added_ff) begin
         add_status = STATUS_ORDER;
      end else if (below_low | at_high) begin
         add_status = STATUS_RANGE;
      end else if (count_ff >= CNT_W'(MAX_IDS)) begin
         add_status = STATUS_FULL;
      end else begin
         add_status = STATUS_OK;
         add_ok     = 1'b1;
      end
   end

   // token entering the chain for an in-range query
   assign link[0] = {accept & (op == OP_QUERY) & ~below_low & ~at_high, req_txn_id, 1'b0};

   // cell chain
   for (genvar i = 0; i < MAX_IDS; i++) begin : g_cell
      svc_cell #(
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (accept & (op == OP_ADD) & add_ok & (count_ff == CNT_W'(i))),
         .wr_id    (req_txn_id),
         .count    (count_ff),
         .tok_prev (link[i]),
         .tok_next (link[i+1])
      );
   end

   assign chain_out = link[MAX_IDS];

   // configuration writes
   always_comb begin
      low_bound_in  = low_bound_ff;
      high_bound_in = high_bound_ff;
      if (csr_valid & csr_ready) begin
         unique case (csr_index)
            CSR_LOW_BOUND:  low_bound_in  = csr_data;
            CSR_HIGH_BOUND: high_bound_in = csr_data;
            default: ;
         endcase
      end
   end

   // list control, state and result register
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      last_added_in  = last_added_ff;
      pend_bad_in    = pend_bad_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_visible_in = rsp_visible_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in   = 1'b1;
               rsp_visible_in = 1'b0;
               rsp_status_in  = base_status;
               rsp_count_in   = count_ff;
               unique case (op)
                  OP_CLEAR: begin
                     count_in      = '0;
                     last_added_in = '0;
                     rsp_count_in  = '0;
                  end
                  OP_ADD: begin
                     rsp_status_in = add_status;
                     if (add_ok) begin
                        count_in      = count_ff + CNT_W'(1);
                        last_added_in = req_txn_id;
                        rsp_count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  OP_QUERY: begin
                     if (below_low) begin
                        rsp_visible_in = 1'b1;
                     end else if (!at_high) begin
                        rsp_valid_in = 1'b0;
                        pend_bad_in  = bad;
                        state_in     = ST_QUERY;
                     end
                  end
                  OP_NONE: ;
                  default: ;
               endcase
            end
         end
         ST_QUERY: begin
            if (chain_out.valid) begin
               rsp_valid_in   = 1'b1;
               rsp_visible_in = ~chain_out.hit;
               rsp_status_in  = pend_bad_ff ? STATUS_BAD_BOUNDS : STATUS_OK;
               rsp_count_in   = count_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         low_bound_ff  <= ID_W'(1);
         high_bound_ff <= ID_W'(1);
         count_ff      <= '0;
         last_added_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         low_bound_ff  <= low_bound_in;
         high_bound_ff <= high_bound_in;
         count_ff      <= count_in;
         last_added_ff <= last_added_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_bad_ff    <= pend_bad_in;
      rsp_visible_ff <= rsp_visible_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_visible    = rsp_visible_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_list_count = LIST_COUNT_W'(rsp_count_ff);

   // no item is shown while a query token is still in the chain
   a_query_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QUERY) |-> !rsp_valid_ff)
      else $error("item shown during query walk");

   // fill count never passes the store depth
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_IDS))
      else $error("list count beyond store depth");

   // a token leaves the chain only while a query is pending
   a_token_state: assert property (@(posedge clock) disable iff (reset)
      chain_out.valid |-> (state_ff == ST_QUERY))
      else $error("stray token at chain end");

   // a successful add grows the list by exactly one
   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_ADD && add_ok) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("add did not grow list by one");

endmodule
